// ===== rtl/core/gda_pkg.sv =====
// Shared types, constants and calendar tables for the Gregorian date arithmetic unit.
// Has no dependencies. It is used by gda_ctrl, gda_datapath and the top level.
package gda_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned DistW   = 22;
  // A signed day number holds the range from a full offset before 0001-01-01
  // to a full offset past 9999-12-31.
  localparam int unsigned SerW    = 24;
  localparam int unsigned RemW    = 22;
  localparam int unsigned QuotW   = 7;

  localparam int unsigned YearMax    = 9999;
  localparam int unsigned MonthMax   = 12;
  localparam int unsigned LastSerial = 3652058;
  localparam int unsigned Days400    = 146097;
  localparam int unsigned Days100    = 36524;
  localparam int unsigned Days4      = 1461;
  localparam int unsigned Days1      = 365;
  // floor(y / 100) is (y * Recip100) >> RecipShift for every y below 10000.
  localparam int unsigned Recip100   = 5243;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW      = 26;

  // Operation codes. The spare code behaves as a compare.
  localparam logic [1:0] FuncAdd = 2'd0;
  localparam logic [1:0] FuncSub = 2'd1;
  localparam logic [1:0] FuncCmp = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [OffsetW-1:0] offset;
    logic [YearW-1:0]   other_year;
    logic [MonthW-1:0]  other_month;
    logic [DayW-1:0]    other_day;
  } gda_req_t;

  typedef struct packed {
    logic [YearW-1:0]  out_year;
    logic [MonthW-1:0] out_month;
    logic [DayW-1:0]   out_day;
    logic [DistW-1:0]  day_distance;
    logic              is_greater;
    logic              is_equal;
    logic              date_valid;
    logic              out_of_range;
  } gda_res_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SER_MUL,
    OP_SER_YEAR,
    OP_SER_SUM,
    OP_ARITH,
    OP_C400,
    OP_C100,
    OP_C4,
    OP_C1,
    OP_CMON
  } gda_op_e;

  typedef struct packed {
    gda_op_e op;
    logic    sel_b;
    logic    publish;
  } gda_cmd_t;

  typedef struct packed {
    logic is_cmp;
    logic step_done;
  } gda_sts_t;

  // Length of a month in a common year.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of the given month.
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/gda_ctrl.sv =====
// Sequencing state machine of the Gregorian date arithmetic unit.
// Depends on gda_pkg; drives gda_datapath through command and status structs.
module gda_ctrl import gda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  gda_sts_t sts_i,
  output gda_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SER_MUL,
    S_SER_YEAR,
    S_SER_SUM,
    S_ARITH,
    S_C400,
    S_C100,
    S_C4,
    S_C1,
    S_CMON,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   sel_b_q, sel_b_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   publish;

  assign accept  = (state_q == S_IDLE) && in_valid_i;
  assign publish = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd_o.sel_b   = sel_b_q;
    cmd_o.publish = publish;
    case (state_q)
      S_IDLE:     cmd_o.op = accept ? OP_LOAD : OP_NONE;
      S_SER_MUL:  cmd_o.op = OP_SER_MUL;
      S_SER_YEAR: cmd_o.op = OP_SER_YEAR;
      S_SER_SUM:  cmd_o.op = OP_SER_SUM;
      S_ARITH:    cmd_o.op = OP_ARITH;
      S_C400:     cmd_o.op = OP_C400;
      S_C100:     cmd_o.op = OP_C100;
      S_C4:       cmd_o.op = OP_C4;
      S_C1:       cmd_o.op = OP_C1;
      S_CMON:     cmd_o.op = OP_CMON;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    sel_b_d     = sel_b_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SER_MUL;
          sel_b_d = 1'b0;
        end
      end
      S_SER_MUL:  state_d = S_SER_YEAR;
      S_SER_YEAR: state_d = S_SER_SUM;
      S_SER_SUM: begin
        if (!sel_b_q && sts_i.is_cmp) begin
          sel_b_d = 1'b1;
          state_d = S_SER_MUL;
        end else begin
          state_d = S_ARITH;
        end
      end
      S_ARITH: state_d = S_C400;
      S_C400:  if (sts_i.step_done) state_d = S_C100;
      S_C100:  if (sts_i.step_done) state_d = S_C4;
      S_C4:    if (sts_i.step_done) state_d = S_C1;
      S_C1:    if (sts_i.step_done) state_d = S_CMON;
      S_CMON:  if (sts_i.step_done) state_d = S_FINISH;
      S_FINISH: begin
        if (publish) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_b_q     <= sel_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // A result is only written into a free or draining output register.
  a_publish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    publish |-> (!out_valid_q || !out_stall_i))
    else $error("result published over a waiting result");

  // An accepted request always starts with the first date's day number.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SER_MUL && !sel_b_q))
    else $error("accepted request did not start the day number pass");

  // A new result appears only straight out of the finishing state.
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FINISH)
    else $error("result valid raised outside the finishing state");

endmodule

// ===== rtl/core/gda_datapath.sv =====
// Datapath of the Gregorian date arithmetic unit: day numbers, offset arithmetic,
// and the stepwise conversion back to a date. Depends on gda_pkg.
module gda_datapath import gda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  gda_req_t req_i,
  input  gda_cmd_t cmd_i,
  output gda_sts_t sts_o,
  output gda_res_t res_o
);

  gda_req_t              req_q;
  logic [YearW-1:0]      yc_q;
  logic [MonthW-1:0]     mc_q;
  logic [DayW-1:0]       dy_q;
  logic [QuotW-1:0]      q_q;
  logic [RemW-1:0]       sy_q;
  logic                  leap_q;
  logic signed [SerW-1:0] sa_q, sb_q;
  logic                  valid_q;
  logic [RemW-1:0]       r_q;
  logic                  sat_q;
  logic [DistW-1:0]      dist_q;
  logic                  gt_q, eq_q;
  logic [YearW-1:0]      year_q;
  logic [1:0]            n100_q;
  logic [4:0]            n4_q;
  logic [1:0]            n1_q;
  logic [MonthW-1:0]     mm_q;
  gda_res_t              res_q;

  // Operand selection and clamping for the day number pass.
  logic [YearW-1:0]  ysel, yc;
  logic [MonthW-1:0] msel, mc;
  logic [ProdW-1:0]  prod;

  always_comb begin
    ysel = cmd_i.sel_b ? req_q.other_year  : req_q.year;
    msel = cmd_i.sel_b ? req_q.other_month : req_q.month;
    if (ysel == '0) begin
      yc = YearW'(1);
    end else if (ysel > YearW'(YearMax)) begin
      yc = YearW'(YearMax);
    end else begin
      yc = ysel;
    end
    if (msel == '0) begin
      mc = MonthW'(1);
    end else if (msel > MonthW'(MonthMax)) begin
      mc = MonthW'(MonthMax);
    end else begin
      mc = msel;
    end
    prod = ProdW'(yc) * ProdW'(Recip100);
  end

  // Year part of the day number: 365 p + p/4 - p/100 + p/400, p = year - 1.
  logic [YearW-1:0] rem100, p;
  logic             century, leap_y;
  logic [QuotW-1:0] p100;
  logic [4:0]       p400;
  logic [RemW-1:0]  sy;

  always_comb begin
    rem100  = yc_q - YearW'(q_q) * YearW'(100);
    century = (rem100 == '0);
    leap_y  = (yc_q[1:0] == 2'b00) && (!century || q_q[1:0] == 2'b00);
    p       = yc_q - YearW'(1);
    p100    = q_q - QuotW'(century);
    p400    = 5'(q_q >> 2) - 5'(century && q_q[1:0] == 2'b00);
    sy      = RemW'(p) * RemW'(Days1) + RemW'(p >> 2) - RemW'(p100) + RemW'(p400);
  end

  // Month and day part, and the check of the first date.
  logic [DayW-1:0]        dim_s;
  logic [SerW-1:0]        s_sum;
  logic                   raw_ok;

  always_comb begin
    dim_s  = month_len(mc_q) + DayW'(mc_q == 4'd2 && leap_q);
    s_sum  = SerW'(sy_q) + SerW'(days_before(mc_q)) + SerW'(leap_q && mc_q > 4'd2)
           + SerW'(dy_q) - SerW'(1);
    raw_ok = (req_q.year != '0) && (req_q.year <= YearW'(YearMax))
          && (req_q.month != '0) && (req_q.month <= MonthW'(MonthMax))
          && (req_q.day != '0) && (req_q.day <= dim_s);
  end

  // Offset arithmetic, saturation and compare.
  logic signed [SerW-1:0] r_ext, diff;
  logic                   is_cmp;

  always_comb begin
    is_cmp = req_q.func[1];
    if (req_q.func == FuncAdd) begin
      r_ext = sa_q + $signed(SerW'(req_q.offset));
    end else if (req_q.func == FuncSub) begin
      r_ext = sa_q - $signed(SerW'(req_q.offset));
    end else begin
      r_ext = sa_q;
    end
    diff = sa_q - sb_q;
  end

  // Conversion back to a date: leap year of the current year and month length.
  logic            leap_c;
  logic [DayW-1:0] dim_c;

  always_comb begin
    leap_c = (n1_q == 2'd3) && (n4_q != 5'd24 || n100_q == 2'd3);
    dim_c  = month_len(mm_q) + DayW'(mm_q == 4'd2 && leap_c);
  end

  always_comb begin
    sts_o.is_cmp = is_cmp;
    case (cmd_i.op)
      OP_C400: sts_o.step_done = (r_q < RemW'(Days400));
      OP_C100: sts_o.step_done = (r_q < RemW'(Days100)) || (n100_q == 2'd3);
      OP_C4:   sts_o.step_done = (r_q < RemW'(Days4));
      OP_C1:   sts_o.step_done = (r_q < RemW'(Days1)) || (n1_q == 2'd3);
      OP_CMON: sts_o.step_done = (mm_q == MonthW'(MonthMax)) || (r_q < RemW'(dim_c));
      default: sts_o.step_done = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_q <= req_i;
      end
      OP_SER_MUL: begin
        yc_q <= yc;
        mc_q <= mc;
        dy_q <= cmd_i.sel_b ? req_q.other_day : req_q.day;
        q_q  <= prod[RecipShift +: QuotW];
      end
      OP_SER_YEAR: begin
        sy_q   <= sy;
        leap_q <= leap_y;
      end
      OP_SER_SUM: begin
        if (cmd_i.sel_b) begin
          sb_q <= $signed(s_sum);
        end else begin
          sa_q    <= $signed(s_sum);
          valid_q <= raw_ok;
        end
      end
      OP_ARITH: begin
        if (r_ext < 0) begin
          r_q   <= '0;
          sat_q <= 1'b1;
        end else if (r_ext > $signed(SerW'(LastSerial))) begin
          r_q   <= RemW'(LastSerial);
          sat_q <= 1'b1;
        end else begin
          r_q   <= RemW'(r_ext);
          sat_q <= 1'b0;
        end
        gt_q   <= is_cmp && (diff > 0);
        eq_q   <= is_cmp && (diff == 0);
        dist_q <= !is_cmp ? '0 : (diff < 0 ? DistW'(-diff) : DistW'(diff));
        year_q <= YearW'(1);
        n100_q <= '0;
        n4_q   <= '0;
        n1_q   <= '0;
        mm_q   <= MonthW'(1);
      end
      OP_C400: begin
        if (r_q >= RemW'(Days400)) begin
          r_q    <= r_q - RemW'(Days400);
          year_q <= year_q + YearW'(400);
        end
      end
      OP_C100: begin
        if (r_q >= RemW'(Days100) && n100_q != 2'd3) begin
          r_q    <= r_q - RemW'(Days100);
          year_q <= year_q + YearW'(100);
          n100_q <= n100_q + 2'd1;
        end
      end
      OP_C4: begin
        if (r_q >= RemW'(Days4)) begin
          r_q    <= r_q - RemW'(Days4);
          year_q <= year_q + YearW'(4);
          n4_q   <= n4_q + 5'd1;
        end
      end
      OP_C1: begin
        if (r_q >= RemW'(Days1) && n1_q != 2'd3) begin
          r_q    <= r_q - RemW'(Days1);
          year_q <= year_q + YearW'(1);
          n1_q   <= n1_q + 2'd1;
        end
      end
      OP_CMON: begin
        if (mm_q != MonthW'(MonthMax) && r_q >= RemW'(dim_c)) begin
          r_q  <= r_q - RemW'(dim_c);
          mm_q <= mm_q + MonthW'(1);
        end
      end
      default: begin
      end
    endcase

    if (cmd_i.publish) begin
      res_q.out_year     <= year_q;
      res_q.out_month    <= mm_q;
      res_q.out_day      <= r_q[DayW-1:0] + DayW'(1);
      res_q.day_distance <= dist_q;
      res_q.is_greater   <= gt_q;
      res_q.is_equal     <= eq_q;
      res_q.date_valid   <= valid_q;
      res_q.out_of_range <= sat_q;
    end
  end

  assign res_o = res_q;

  // What remains of the day count must fit in one month when a result is written.
  a_day_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> (r_q < RemW'(31)) && (mm_q != '0) && (mm_q <= MonthW'(MonthMax)))
    else $error("day count left over after the month walk");

  // The year built up by the conversion stays inside the calendar range.
  a_year_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> (year_q != '0) && (year_q <= YearW'(YearMax)))
    else $error("converted year out of range");

endmodule

// ===== rtl/core/gregorian_date_arithmetic_unit.sv =====
// Top level of the Gregorian date arithmetic unit.
// Depends on gda_pkg, gda_ctrl and gda_datapath.
//
//   Channel  Direction  Handshake                 Carries
//   in       input      in_valid_i / in_stall_o   gda_req_t: operation, two dates, offset
//   out      output     out_valid_o / out_stall_i gda_res_t: date, distance, flags
//
// One request is worked on at a time. A compare also runs the day number pass for
// the second date. The time from acceptance to result depends on the conversion
// back to a date, which steps through 400-year, 100-year, 4-year and 1-year
// periods and then months, one subtraction a cycle. Reset is asynchronous and
// active low and clears the controller only. A result waits in the output register
// while the output is stalled; the next request is accepted and worked on
// meanwhile, and is held back only when the output register is still full at
// the end of it.
module gregorian_date_arithmetic_unit import gda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gda_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gda_res_t out_res_o
);

  // The controller sequences the datapath through its passes; the datapath reports
  // whether the request is a compare and whether the current conversion step is done.
  gda_cmd_t cmd;
  gda_sts_t sts;

  gda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the captured request, the day numbers of both dates, the
  // conversion counters and the output register.
  gda_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (out_res_o)
  );

endmodule
